>>> rtl/sign_magnitude_calc_to_decimal_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sign-magnitude calculator
// Clocked checks that are compiled away when NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef SIGN_MAGNITUDE_CALC_TO_DECIMAL_UNIT_ASSERT_SVH
`define SIGN_MAGNITUDE_CALC_TO_DECIMAL_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Condition must hold at every edge outside reset
`define SMCD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Trigger implies a condition at the next edge
`define SMCD_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`else

`define SMCD_ASSERT_ALWAYS(lbl, cond, msg)
`define SMCD_ASSERT_NEXT(lbl, trig, cond, msg)

`endif

`endif

>>> rtl/smcd_pkg.sv
// ---------------------------------------------------------------------------
// Sign-magnitude calculator package
// Item types, operation codes, character constants and datapath sizes.
// ---------------------------------------------------------------------------
`default_nettype none

package smcd_pkg;

  // Operation codes
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Output characters
  localparam logic [6:0] CH_NUL   = 7'd0;
  localparam logic [6:0] CH_ZERO  = 7'd48;
  localparam logic [6:0] CH_MINUS = 7'd45;
  localparam logic [6:0] CH_POINT = 7'd46;

  // Datapath sizes
  localparam int OPND_W     = 8;
  localparam int MAG_W      = 16;
  localparam int FRAC_W     = 12;
  localparam int CNT_W      = 5;
  localparam int DIV_STEPS  = 8;
  localparam int FRAC_STEPS = 12;
  localparam int CONV_STEPS = 16;

  localparam logic [3:0] DIGIT_MAX = 4'd9;
  localparam logic [3:0] TEN       = 4'd10;

  typedef struct packed {
    logic [1:0]        operation;
    logic [OPND_W-1:0] magnitude_a;
    logic              negative_a;
    logic [OPND_W-1:0] magnitude_b;
    logic              negative_b;
  } cmd_t;

  typedef struct packed {
    logic [6:0] character;
    logic       last_char;
    logic       divide_by_zero;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/sign_magnitude_calc_to_decimal_unit.sv
// ---------------------------------------------------------------------------
// Sign-magnitude calculator with decimal character output
// Computes add, subtract, multiply or divide on sign-magnitude operands and
// streams the result as ASCII characters, one item per character.
// ---------------------------------------------------------------------------
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+--------------------------
//  cmd     | in  | cmd_valid / cmd_ready     | smcd_pkg::cmd_t
//  result  | out | result_valid / result_ready | smcd_pkg::result_t
//
// Add, subtract and multiply run the 16-step shift-and-add-3 binary to decimal
// loop; divide first runs the shared restoring divider (8 quotient steps, 12
// steps for the tenths digit). A zero divisor skips both and goes straight to
// the error item. A leading '-' goes out from the sign state.
// cmd_ready is high only while the sequencer is idle. A stalled result holds
// the sequencer in its emit state until the result is taken. Reset (rst,
// synchronous) returns to idle and drops any pending result.
// ---------------------------------------------------------------------------
`default_nettype none

module sign_magnitude_calc_to_decimal_unit #(
  parameter int DIGIT_COUNT = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  output logic                   cmd_ready,
  input  wire smcd_pkg::cmd_t    cmd,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output smcd_pkg::result_t      result
);

`include "sign_magnitude_calc_to_decimal_unit_assert.svh"

  localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_TENTH, S_CONV, S_SIGN, S_DIGIT, S_POINT, S_FRAC, S_ERR
  } state_t;

  state_t                          state;
  logic [smcd_pkg::MAG_W-1:0]      dvd;
  logic [smcd_pkg::OPND_W-1:0]     rem;
  logic [smcd_pkg::OPND_W-1:0]     divisor;
  logic [smcd_pkg::OPND_W-1:0]     quot;
  logic [3:0]                      tenth;
  logic                            neg;
  logic                            frac_nz;
  logic [smcd_pkg::CNT_W-1:0]      cnt;
  logic [IDX_W-1:0]                dig_idx;
  logic [3:0]                      bcd [DIGIT_COUNT];

  // Combinational helpers
  logic                            load_ok;
  logic                            emit;
  logic                            eff_nb;
  logic                            a_gt;
  logic                            b_gt;
  logic [smcd_pkg::OPND_W:0]       addsub_mag;
  logic                            addsub_neg;
  logic [smcd_pkg::MAG_W-1:0]      product;
  logic [smcd_pkg::OPND_W:0]       rem_sh;
  logic [smcd_pkg::OPND_W:0]       rem_diff;
  logic                            take;
  logic [smcd_pkg::OPND_W-1:0]     step_rem;
  logic [smcd_pkg::MAG_W-1:0]      step_dvd;
  logic [smcd_pkg::FRAC_W-1:0]     ten_rem;
  logic [3:0]                      bcd_adj [DIGIT_COUNT];
  logic [IDX_W-1:0]                top;
  logic                            cnt_done;

  assign cmd_ready = (state == S_IDLE);
  assign load_ok   = !result_valid || result_ready;
  assign cnt_done  = (cnt == '0);

  // Load a character into the output register this cycle
  assign emit = load_ok && ((state == S_SIGN && neg) || state == S_DIGIT ||
                            state == S_POINT || state == S_FRAC || state == S_ERR);

  // Add and subtract in sign-magnitude: flip b's sign for subtract
  always_comb begin
    eff_nb = (cmd.operation == smcd_pkg::OP_SUB) ? !cmd.negative_b : cmd.negative_b;
    a_gt   = cmd.magnitude_a > cmd.magnitude_b;
    b_gt   = cmd.magnitude_b > cmd.magnitude_a;
    if (cmd.negative_a == eff_nb) begin
      addsub_mag = {1'b0, cmd.magnitude_a} + {1'b0, cmd.magnitude_b};
      addsub_neg = cmd.negative_a;
    end else begin
      addsub_mag = a_gt ? {1'b0, cmd.magnitude_a - cmd.magnitude_b}
                        : {1'b0, cmd.magnitude_b - cmd.magnitude_a};
      addsub_neg = cmd.negative_a ? a_gt : b_gt;
    end
  end

  assign product = smcd_pkg::MAG_W'(cmd.magnitude_a) * smcd_pkg::MAG_W'(cmd.magnitude_b);

  // Shared restoring divider step: shift one dividend bit into the remainder
  always_comb begin
    rem_sh   = {rem, dvd[smcd_pkg::MAG_W-1]};
    rem_diff = rem_sh - {1'b0, divisor};
    take     = rem_sh >= {1'b0, divisor};
    step_rem = take ? rem_diff[smcd_pkg::OPND_W-1:0] : rem_sh[smcd_pkg::OPND_W-1:0];
    step_dvd = {dvd[smcd_pkg::MAG_W-2:0], take};
  end

  // Ten times the final remainder, dividend of the tenths division
  assign ten_rem = smcd_pkg::FRAC_W'(step_rem) * smcd_pkg::FRAC_W'(smcd_pkg::TEN);

  // Add 3 to every decimal digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      bcd_adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
  end

  // Highest nonzero digit; the lowest digit always prints
  always_comb begin
    top = '0;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (bcd[i] != 4'd0) top = IDX_W'(i);
    end
  end

  // Sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && !emit) result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            divisor <= cmd.magnitude_b;
            frac_nz <= 1'b0;
            for (int i = 0; i < DIGIT_COUNT; i++) bcd[i] <= 4'd0;
            if (cmd.operation == smcd_pkg::OP_DIV && cmd.magnitude_b == '0) begin
              state <= S_ERR;
            end else if (cmd.operation == smcd_pkg::OP_DIV) begin
              neg   <= cmd.negative_a ^ cmd.negative_b;
              dvd   <= {cmd.magnitude_a, {smcd_pkg::OPND_W{1'b0}}};
              rem   <= '0;
              cnt   <= smcd_pkg::CNT_W'(smcd_pkg::DIV_STEPS - 1);
              state <= S_DIV;
            end else if (cmd.operation == smcd_pkg::OP_MUL) begin
              neg   <= cmd.negative_a ^ cmd.negative_b;
              dvd   <= product;
              cnt   <= smcd_pkg::CNT_W'(smcd_pkg::CONV_STEPS - 1);
              state <= S_CONV;
            end else begin
              neg   <= addsub_neg;
              dvd   <= smcd_pkg::MAG_W'(addsub_mag);
              cnt   <= smcd_pkg::CNT_W'(smcd_pkg::CONV_STEPS - 1);
              state <= S_CONV;
            end
          end
        end
        S_DIV: begin
          if (cnt_done) begin
            // Keep quotient, then divide ten times the remainder
            quot    <= step_dvd[smcd_pkg::OPND_W-1:0];
            frac_nz <= (step_rem != '0);
            rem     <= '0;
            dvd     <= {ten_rem, 4'h0};
            cnt     <= smcd_pkg::CNT_W'(smcd_pkg::FRAC_STEPS - 1);
            state   <= S_TENTH;
          end else begin
            cnt <= cnt - 1'b1;
            rem <= step_rem;
            dvd <= step_dvd;
          end
        end
        S_TENTH: begin
          if (cnt_done) begin
            tenth <= step_dvd[3:0];
            dvd   <= smcd_pkg::MAG_W'(quot);
            cnt   <= smcd_pkg::CNT_W'(smcd_pkg::CONV_STEPS - 1);
            state <= S_CONV;
          end else begin
            cnt <= cnt - 1'b1;
            rem <= step_rem;
            dvd <= step_dvd;
          end
        end
        S_CONV: begin
          // Shift binary value into the decimal digits
          cnt    <= cnt - 1'b1;
          bcd[0] <= {bcd_adj[0][2:0], dvd[smcd_pkg::MAG_W-1]};
          for (int i = 1; i < DIGIT_COUNT; i++) begin
            bcd[i] <= {bcd_adj[i][2:0], bcd_adj[i-1][3]};
          end
          dvd <= {dvd[smcd_pkg::MAG_W-2:0], 1'b0};
          if (cnt_done) state <= S_SIGN;
        end
        S_SIGN: begin
          if (!neg) begin
            dig_idx <= top;
            state   <= S_DIGIT;
          end else if (load_ok) begin
            result       <= '{character: smcd_pkg::CH_MINUS, last_char: 1'b0,
                              divide_by_zero: 1'b0};
            result_valid <= 1'b1;
            dig_idx      <= top;
            state        <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          if (load_ok) begin
            result       <= '{character: smcd_pkg::CH_ZERO + {3'b000, bcd[dig_idx]},
                              last_char: (dig_idx == '0) && !frac_nz,
                              divide_by_zero: 1'b0};
            result_valid <= 1'b1;
            if (dig_idx == '0) begin
              state <= frac_nz ? S_POINT : S_IDLE;
            end else begin
              dig_idx <= dig_idx - 1'b1;
            end
          end
        end
        S_POINT: begin
          if (load_ok) begin
            result       <= '{character: smcd_pkg::CH_POINT, last_char: 1'b0,
                              divide_by_zero: 1'b0};
            result_valid <= 1'b1;
            state        <= S_FRAC;
          end
        end
        S_FRAC: begin
          if (load_ok) begin
            result       <= '{character: smcd_pkg::CH_ZERO + {3'b000, tenth},
                              last_char: 1'b1, divide_by_zero: 1'b0};
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        S_ERR: begin
          if (load_ok) begin
            result       <= '{character: smcd_pkg::CH_NUL, last_char: 1'b1,
                              divide_by_zero: 1'b1};
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  `SMCD_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready, "ready after accept")
  `SMCD_ASSERT_ALWAYS(a_err_is_last, !(result_valid && result.divide_by_zero) || result.last_char, "error not last")
  `SMCD_ASSERT_ALWAYS(a_tenth_range, state != S_FRAC || tenth <= smcd_pkg::DIGIT_MAX, "tenths digit out of range")
  `SMCD_ASSERT_ALWAYS(a_idx_range, state != S_DIGIT || dig_idx <= IDX_W'(DIGIT_COUNT - 1), "digit index out of range")

endmodule

`default_nettype wire
